### design/oled_page_framebuffer_flush_macros.svh
// Assertion macros shared by the frame buffer flush design.
// Depends on nothing; included by the top level only.
`ifndef OLED_PAGE_FRAMEBUFFER_FLUSH_MACROS_SVH
`define OLED_PAGE_FRAMEBUFFER_FLUSH_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define OPFF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define OPFF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/opff_pkg.sv
// Package for the page frame buffer flush block: geometry, codes and word types.
// Depends on nothing; imported by the stream sequencer and the top level.
`timescale 1ns / 1ps

package opff_pkg;

  // Panel geometry.
  localparam int unsigned Columns    = 128;
  localparam int unsigned Rows       = 64;
  localparam int unsigned StoreDepth = Columns * 8;
  localparam int unsigned StoreAddrW = $clog2(StoreDepth);
  localparam int unsigned Half       = Columns / 2;
  localparam int unsigned Pages      = Rows / 8;
  localparam int unsigned PageBytes  = 6 + 2 * Half;
  localparam int unsigned PageW      = 3;
  localparam int unsigned PosW       = 8;

  // Positions inside the byte stream of one page.
  localparam logic [PosW-1:0] PosCtrlCmd    = PosW'(0);
  localparam logic [PosW-1:0] PosColLow     = PosW'(1);
  localparam logic [PosW-1:0] PosColHigh    = PosW'(2);
  localparam logic [PosW-1:0] PosPageCmd    = PosW'(3);
  localparam logic [PosW-1:0] PosData1Ctrl  = PosW'(4);
  localparam logic [PosW-1:0] PosData1First = PosW'(5);
  localparam logic [PosW-1:0] PosData1Last  = PosW'(4 + Half);
  localparam logic [PosW-1:0] PosData2Ctrl  = PosW'(5 + Half);
  localparam logic [PosW-1:0] PosData2Skew  = PosW'(6);
  localparam logic [PosW-1:0] PosLast       = PosW'(PageBytes - 1);

  // Bus stream byte codes.
  localparam logic [7:0] ByteCtrlCmd  = 8'h00;
  localparam logic [7:0] ByteCtrlData = 8'h40;
  localparam logic [7:0] CmdColLow    = 8'h00;
  localparam logic [7:0] CmdColHigh   = 8'h10;
  localparam logic [7:0] CmdPage      = 8'hB0;
  localparam logic [7:0] NibbleMask   = 8'h0F;
  localparam logic [7:0] ColStartRst  = 8'h02;

  typedef enum logic [2:0] {
    KIND_SET_PIXEL    = 3'd0,
    KIND_CLEAR_PIXEL  = 3'd1,
    KIND_CLEAR_SCREEN = 3'd2,
    KIND_UPDATE       = 3'd3,
    KIND_TICK         = 3'd4,
    KIND_BYTE_SLOT    = 3'd5
  } opff_kind_e;

  typedef enum logic [1:0] {
    ST_WIPE,
    ST_IDLE,
    ST_MODIFY,
    ST_EMIT
  } opff_state_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } opff_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       transfer_first;
    logic       transfer_last;
    logic       flush_last;
  } opff_out_t;

  // Commands from the top level to the stream sequencer.
  typedef struct packed {
    logic tick;
    logic update;
    logic advance;
  } opff_ctrl_t;

  // What the stream sequencer offers for the current position.
  typedef struct packed {
    logic                  active;
    logic                  is_data;
    logic [StoreAddrW-1:0] addr;
    opff_out_t             word;
  } opff_slot_t;

endpackage

### design/opff_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module opff_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/opff_stream.sv
// Flush stream sequencer: dirty flag, page and byte position, stream formatting.
// Depends on opff_pkg.
`timescale 1ns / 1ps

module opff_stream (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  opff_pkg::opff_ctrl_t ctrl_i,
  input  logic [7:0]         column_start_i,
  output opff_pkg::opff_slot_t slot_o
);
  import opff_pkg::*;

  logic             dirty_q, dirty_d;
  logic             active_q, active_d;
  logic [PageW-1:0] page_q, page_d;
  logic [PosW-1:0]  pos_q, pos_d;

  logic                  page_end;
  logic                  frame_end;
  logic [StoreAddrW-1:0] base;

  assign page_end  = (pos_q == PosLast);
  assign frame_end = (page_q == PageW'(Pages - 1));
  assign base      = StoreAddrW'(page_q) * StoreAddrW'(Columns);

  // Sequencer state update.
  always_comb begin
    dirty_d  = dirty_q;
    active_d = active_q;
    page_d   = page_q;
    pos_d    = pos_q;
    if (ctrl_i.update) begin
      dirty_d = 1'b1;
    end
    if (ctrl_i.tick && !active_q && dirty_q) begin
      dirty_d  = 1'b0;
      active_d = 1'b1;
      page_d   = '0;
      pos_d    = '0;
    end
    if (ctrl_i.advance && active_q) begin
      if (page_end) begin
        pos_d = '0;
        if (frame_end) begin
          active_d = 1'b0;
          page_d   = '0;
        end else begin
          page_d = page_q + PageW'(1);
        end
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q  <= 1'b1;
      active_q <= 1'b0;
      page_q   <= '0;
      pos_q    <= '0;
    end else begin
      dirty_q  <= dirty_d;
      active_q <= active_d;
      page_q   <= page_d;
      pos_q    <= pos_d;
    end
  end

  // Stream word for the current position: command transfer, then two data transfers.
  always_comb begin
    slot_o                     = '0;
    slot_o.active              = active_q;
    slot_o.word.flush_last     = page_end && frame_end;
    if (pos_q < PosData1Ctrl) begin
      slot_o.word.transfer_first = (pos_q == PosCtrlCmd);
      slot_o.word.transfer_last  = (pos_q == PosPageCmd);
      case (pos_q)
        PosCtrlCmd: slot_o.word.out_byte = ByteCtrlCmd;
        PosColLow:  slot_o.word.out_byte = CmdColLow | (column_start_i & NibbleMask);
        PosColHigh: slot_o.word.out_byte = CmdColHigh | (column_start_i >> 4);
        default:    slot_o.word.out_byte = CmdPage | {5'b0, page_q};
      endcase
    end else if (pos_q == PosData1Ctrl) begin
      slot_o.word.out_byte       = ByteCtrlData;
      slot_o.word.transfer_first = 1'b1;
    end else if (pos_q < PosData2Ctrl) begin
      slot_o.is_data             = 1'b1;
      slot_o.addr                = base + StoreAddrW'(pos_q - PosData1First);
      slot_o.word.transfer_last  = (pos_q == PosData1Last);
    end else if (pos_q == PosData2Ctrl) begin
      slot_o.word.out_byte       = ByteCtrlData;
      slot_o.word.transfer_first = 1'b1;
    end else begin
      // Second half: the column runs on from the first half, past two control words.
      slot_o.is_data             = 1'b1;
      slot_o.addr                = base + StoreAddrW'(pos_q - PosData2Skew);
      slot_o.word.transfer_last  = page_end;
    end
  end

endmodule

### design/oled_page_framebuffer_flush.sv
// Top level of the page frame buffer flush block: sequencer FSM, buffer RAM, output word.
// Depends on opff_pkg, opff_ram, opff_stream and the assertion macro header.
`timescale 1ns / 1ps
`include "oled_page_framebuffer_flush_macros.svh"

// The frame buffer holds one byte per column for each eight-row page, in a
// synchronous RAM of Columns * 8 words. A set or clear pixel word is handled as
// a RAM read, then a write-back of the modified byte; a byte slot word during a
// flush passes through a RAM read or stream constant, then the output register,
// and waits only while the previous result word is still held. Update, tick and
// ignored words complete in the cycle in which they are accepted. After reset and after every
// clear-screen word, a clearing pass writes zero to each RAM word, one per
// cycle; no word is accepted during the pass, but column_start writes are
// taken as usual.
module oled_page_framebuffer_flush (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  opff_pkg::opff_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output opff_pkg::opff_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i
);
  import opff_pkg::*;

  opff_state_e state_q, state_d;

  logic [7:0]            column_start_q;
  logic [StoreAddrW-1:0] wipe_cnt_q, wipe_cnt_d;
  logic [StoreAddrW-1:0] addr_q;
  logic [7:0]            mask_q;
  logic                  set_q;
  logic                  pend_data_q;
  opff_out_t             pend_q;
  opff_out_t             out_q, out_d;
  logic                  out_valid_q;

  logic                  accept;
  logic                  pix_hit;
  logic [StoreAddrW-1:0] pix_idx;
  logic [7:0]            pix_mask;
  logic                  wipe_done;
  logic                  emit_load;

  logic                  ram_we;
  logic [StoreAddrW-1:0] ram_waddr;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  logic [StoreAddrW-1:0] ram_raddr;
  logic [7:0]            ram_rdata;

  opff_ctrl_t            ctrl;
  opff_slot_t            slot;

  // Pixel addressing.
  assign pix_hit  = (in_data_i.pos_x < PosW'(Columns)) && (in_data_i.pos_y < PosW'(Rows));
  assign pix_idx  = StoreAddrW'(in_data_i.pos_x)
                  + StoreAddrW'(in_data_i.pos_y[5:3]) * StoreAddrW'(Columns);
  assign pix_mask = 8'(1) << in_data_i.pos_y[2:0];

  assign wipe_done = (wipe_cnt_q == StoreAddrW'(StoreDepth - 1));
  assign accept    = in_valid_i && in_ready_o;
  assign emit_load = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WIPE: begin
        if (wipe_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.kind)
            KIND_SET_PIXEL, KIND_CLEAR_PIXEL: begin
              if (pix_hit) state_d = ST_MODIFY;
            end
            KIND_CLEAR_SCREEN: state_d = ST_WIPE;
            KIND_BYTE_SLOT: begin
              if (slot.active) state_d = ST_EMIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_MODIFY: state_d = ST_IDLE;
      ST_EMIT: begin
        if (emit_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: handshake, RAM ports and sequencer commands.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = set_q ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);
    ram_re     = 1'b0;
    ram_raddr  = pix_idx;
    ctrl       = '0;
    wipe_cnt_d = '0;
    case (state_q)
      ST_WIPE: begin
        ram_we     = 1'b1;
        ram_waddr  = wipe_cnt_q;
        ram_wdata  = '0;
        wipe_cnt_d = wipe_done ? '0 : wipe_cnt_q + StoreAddrW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.kind)
            KIND_SET_PIXEL, KIND_CLEAR_PIXEL: ram_re = pix_hit;
            KIND_UPDATE:                      ctrl.update = 1'b1;
            KIND_TICK:                        ctrl.tick = 1'b1;
            KIND_BYTE_SLOT: begin
              ctrl.advance = 1'b1;
              ram_re       = slot.active && slot.is_data;
              ram_raddr    = slot.addr;
            end
            default: ctrl = '0;
          endcase
        end
      end
      ST_MODIFY: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_WIPE;
      wipe_cnt_q     <= '0;
      column_start_q <= ColStartRst;
      out_valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      wipe_cnt_q <= wipe_cnt_d;
      if (cfg_we_i) begin
        column_start_q <= cfg_data_i;
      end
      if (state_q == ST_EMIT && emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word: data positions take the byte read from the buffer.
  always_comb begin
    out_d = pend_q;
    if (pend_data_q) begin
      out_d.out_byte = ram_rdata;
    end
  end

  // Captured operands for the write-back or output step of a word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q      <= pix_idx;
      mask_q      <= pix_mask;
      set_q       <= (in_data_i.kind == KIND_SET_PIXEL);
      pend_q      <= slot.word;
      pend_data_q <= slot.is_data;
    end
    if (state_q == ST_EMIT && emit_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  opff_ram #(
    .Width(8),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  opff_stream u_stream (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .column_start_i(column_start_q),
    .slot_o        (slot)
  );

  // A read and a write of the buffer never share a cycle in this sequencer.
  `OPFF_ASSERT_ALWAYS(a_no_read_write_overlap, clk_i, !(ram_we && ram_re), "RAM read during write")
  // A write-back always follows the read of the same byte.
  `OPFF_ASSERT(a_modify_after_read, clk_i, rst_ni, (state_q == ST_MODIFY) |-> $past(ram_re), "write-back without read")
  // A pending word is not dropped while the output word is stalled.
  `OPFF_ASSERT(a_emit_holds, clk_i, rst_ni, (state_q == ST_EMIT && out_valid_o && !out_ready_i) |=> (state_q == ST_EMIT), "pending word lost")
  // The end of the flush always closes a transfer.
  `OPFF_ASSERT(a_flush_last_closes, clk_i, rst_ni, (out_valid_o && out_data_o.flush_last) |-> out_data_o.transfer_last, "flush end inside transfer")

endmodule
